### src/greedy_box_nms_top_macros.svh
// Assertion helpers used by the checker file
`ifndef GREEDY_BOX_NMS_TOP_MACROS_SVH
`define GREEDY_BOX_NMS_TOP_MACROS_SVH

// Same-cycle implication, gated by reset
`define GBNMS_CHECK_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated by reset
`define GBNMS_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/gbnms_pkg.sv
package gbnms_pkg;

   localparam int MAX_BOXES = 64;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 7;
   localparam int COORD_W   = 24;
   localparam int SIZE_W    = 16;
   localparam int SCORE_W   = 16;

   localparam logic [15:0] SCORE_THR_RESET = 16'd26214;
   localparam logic [15:0] IOU_THR_RESET   = 16'd19661;

   // configuration register indexes
   localparam logic CSR_SCORE_THR = 1'b0;
   localparam logic CSR_IOU_THR   = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [SIZE_W-1:0]         w;
      logic [SIZE_W-1:0]         h;
   } box_type;

   // one sorted-list entry: score copy, load position, suppressed flag
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [IDX_W-1:0]   idx;
      logic               supp;
   } order_type;

   typedef struct packed {
      logic done;
      logic over;
   } iou_res_type;

endpackage

### src/gbnms_ram.sv
module gbnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port, registered read port that holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/gbnms_iou.sv
module gbnms_iou import gbnms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  box_type       box_a,
   input  box_type       box_b,
   input  logic [15:0]   iou_thr,
   output iou_res_type   res
);

   logic [3:0]         vld_ff;
   logic               done_ff;
   logic               over_ff;

   logic signed [24:0] la, lb, ra, rb, ta, tb, ba, bb;
   logic signed [24:0] x1, x2, y1, y2;
   logic signed [25:0] iw_in, ih_in;
   logic signed [25:0] iw_ff, ih_ff;
   logic [15:0]        wa_ff, ha_ff, wb_ff, hb_ff;
   logic               pos1_ff, pos2_ff, pos3_ff;
   logic [31:0]        inter_ff, area_a_ff, area_b_ff;
   logic [32:0]        uni_ff;
   logic [47:0]        lhs2_ff, lhs3_ff;
   logic [48:0]        prod_ff;

   // edges and overlap extents
   always_comb begin
      la = $signed({box_a.left[COORD_W-1], box_a.left});
      lb = $signed({box_b.left[COORD_W-1], box_b.left});
      ta = $signed({box_a.top[COORD_W-1], box_a.top});
      tb = $signed({box_b.top[COORD_W-1], box_b.top});
      ra = la + $signed({9'b0, box_a.w});
      rb = lb + $signed({9'b0, box_b.w});
      ba = ta + $signed({9'b0, box_a.h});
      bb = tb + $signed({9'b0, box_b.h});
      x1 = (la > lb) ? la : lb;
      y1 = (ta > tb) ? ta : tb;
      x2 = (ra < rb) ? ra : rb;
      y2 = (ba < bb) ? ba : bb;
      iw_in = $signed({x2[24], x2}) - $signed({x1[24], x1});
      ih_in = $signed({y2[24], y2}) - $signed({y1[24], y1});
   end

   // advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         vld_ff  <= {vld_ff[2:0], start};
         done_ff <= vld_ff[3];
      end
   end

   // datapath stages: extents, products, union, scaled union, compare
   always_ff @(posedge clock) begin
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      wa_ff     <= box_a.w;
      ha_ff     <= box_a.h;
      wb_ff     <= box_b.w;
      hb_ff     <= box_b.h;
      pos1_ff   <= (iw_ff > 26'sd0) && (ih_ff > 26'sd0);
      inter_ff  <= iw_ff[15:0] * ih_ff[15:0];
      area_a_ff <= wa_ff * ha_ff;
      area_b_ff <= wb_ff * hb_ff;
      pos2_ff   <= pos1_ff;
      uni_ff    <= {1'b0, area_a_ff} + {1'b0, area_b_ff} - {1'b0, inter_ff};
      lhs2_ff   <= {inter_ff, 16'b0};
      pos3_ff   <= pos2_ff;
      lhs3_ff   <= lhs2_ff;
      prod_ff   <= iou_thr * uni_ff;
      over_ff   <= pos3_ff && ({1'b0, lhs3_ff} > prod_ff);
   end

   assign res.done = done_ff;
   assign res.over = over_ff;

endmodule

### src/greedy_box_nms_top.sv
// Greedy IoU non-maximum suppression over up to 64 boxes. Boxes load one per
// beat. The beat flagged last starts the pass, and the input stalls until
// the last result of the set has entered the output register. Scores and
// boxes live in single-port-read RAMs with a registered read port, and every
// step of the pass is a read, check and write-back on them. The stable
// insertion sort reads each score, skips boxes below the score threshold and
// shifts lower entries up one place to insert each kept box. The suppression
// walk sends each survivor, then runs every later unsuppressed entry through
// the IoU pipeline against it and marks those whose IoU exceeds the threshold.
// Results leave through an output register, one per beat. The final one
// carries last_result, and a set with nothing kept yields one beat with kept
// low.
module greedy_box_nms_top import gbnms_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_box_left,
   input  logic signed [COORD_W-1:0] req_box_top,
   input  logic [SIZE_W-1:0]         req_box_width,
   input  logic [SIZE_W-1:0]         req_box_height,
   input  logic [SCORE_W-1:0]        req_score,
   input  logic                      req_last_box,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [IDX_W-1:0]          rsp_box_index,
   output logic                      rsp_kept,
   output logic                      rsp_last_result,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [15:0]               csr_wr_data
);

   typedef enum logic [10:0] {
      ST_LOAD  = 11'b000_0000_0001,
      ST_SRD   = 11'b000_0000_0010,
      ST_SCHK  = 11'b000_0000_0100,
      ST_SCMP  = 11'b000_0000_1000,
      ST_SINS  = 11'b000_0001_0000,
      ST_PRD   = 11'b000_0010_0000,
      ST_PCHK  = 11'b000_0100_0000,
      ST_PEMIT = 11'b000_1000_0000,
      ST_QRD   = 11'b001_0000_0000,
      ST_QCHK  = 11'b010_0000_0000,
      ST_QWAIT = 11'b100_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] i_ff, i_in, n_ff, n_in, j_ff, j_in;
   logic [CNT_W-1:0] j_m2;
   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   order_type        cur_ff, cur_in, cmp_ff, cmp_in;
   box_type          box_a_ff, box_a_in;
   logic [15:0]      score_thr_ff, iou_thr_ff;
   logic             flush_ff, flush_in;
   logic             wait_ff;
   logic             iou_start;
   iou_res_type      iou_res;

   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic             rsp_kept_ff, rsp_last_ff;
   logic             slot_free;
   logic             push, push_kept, push_last;
   logic [IDX_W-1:0] push_idx;

   logic             box_wr_en, box_rd_en;
   logic [IDX_W-1:0] box_rd_addr;
   box_type          box_wr_data, box_rd_data;
   logic             score_wr_en, score_rd_en;
   logic [SCORE_W-1:0] score_rd_data;
   logic             ord_wr_en, ord_rd_en;
   logic [IDX_W-1:0] ord_wr_addr, ord_rd_addr;
   order_type        ord_wr_data, ord_rd_data;

   assign req_stall   = (state_ff != ST_LOAD) || flush_ff;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign j_m2        = j_ff - CNT_W'(2);
   assign box_wr_data = '{left: req_box_left, top: req_box_top,
                          w: req_box_width, h: req_box_height};

   gbnms_ram #(.WIDTH($bits(box_type)), .DEPTH(MAX_BOXES)) u_box_ram (
      .clock   (clock),
      .wr_en   (box_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (box_wr_data),
      .rd_en   (box_rd_en),
      .rd_addr (box_rd_addr),
      .rd_data (box_rd_data)
   );

   gbnms_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
      .clock   (clock),
      .wr_en   (score_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_score),
      .rd_en   (score_rd_en),
      .rd_addr (i_ff[IDX_W-1:0]),
      .rd_data (score_rd_data)
   );

   gbnms_ram #(.WIDTH($bits(order_type)), .DEPTH(MAX_BOXES)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_wr_en),
      .wr_addr (ord_wr_addr),
      .wr_data (ord_wr_data),
      .rd_en   (ord_rd_en),
      .rd_addr (ord_rd_addr),
      .rd_data (ord_rd_data)
   );

   gbnms_iou u_iou (
      .clock   (clock),
      .reset   (reset),
      .start   (iou_start),
      .box_a   (box_a_ff),
      .box_b   (box_rd_data),
      .iou_thr (iou_thr_ff),
      .res     (iou_res)
   );

   // sequencer: load, sort, suppress, flush
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      n_in          = n_ff;
      j_in          = j_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      cur_in        = cur_ff;
      cmp_in        = cmp_ff;
      box_a_in      = box_a_ff;
      flush_in      = flush_ff;
      iou_start     = 1'b0;
      push          = 1'b0;
      push_kept     = 1'b1;
      push_last     = 1'b0;
      push_idx      = pend_idx_ff;
      box_wr_en     = 1'b0;
      box_rd_en     = 1'b0;
      box_rd_addr   = ord_rd_data.idx;
      score_wr_en   = 1'b0;
      score_rd_en   = 1'b0;
      ord_wr_en     = 1'b0;
      ord_wr_addr   = j_ff[IDX_W-1:0];
      ord_wr_data   = cur_ff;
      ord_rd_en     = 1'b0;
      ord_rd_addr   = i_ff[IDX_W-1:0];

      case (state_ff)
         ST_LOAD: begin
            if (flush_ff) begin
               // deliver the final beat of the set
               if (slot_free) begin
                  push      = 1'b1;
                  push_last = 1'b1;
                  push_kept = pend_valid_ff;
                  push_idx  = pend_valid_ff ? pend_idx_ff : '0;
                  pend_valid_in = 1'b0;
                  flush_in  = 1'b0;
                  count_in  = '0;
               end
            end else if (req_valid) begin
               // store the box unless the set is full
               if (count_ff < CNT_W'(MAX_BOXES)) begin
                  box_wr_en   = 1'b1;
                  score_wr_en = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
               end
               if (req_last_box) begin
                  state_in = ST_SRD;
                  i_in     = '0;
                  n_in     = '0;
               end
            end
         end
         ST_SRD: begin
            if (i_ff == count_ff) begin
               state_in = ST_PRD;
               i_in     = '0;
            end else begin
               score_rd_en = 1'b1;
               state_in    = ST_SCHK;
            end
         end
         ST_SCHK: begin
            if (score_rd_data < score_thr_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_SRD;
            end else begin
               cur_in = '{score: score_rd_data, idx: i_ff[IDX_W-1:0], supp: 1'b0};
               if (n_ff == '0) begin
                  ord_wr_en   = 1'b1;
                  ord_wr_addr = '0;
                  ord_wr_data = cur_in;
                  n_in        = n_ff + CNT_W'(1);
                  i_in        = i_ff + CNT_W'(1);
                  state_in    = ST_SRD;
               end else begin
                  j_in        = n_ff;
                  ord_rd_en   = 1'b1;
                  ord_rd_addr = n_ff[IDX_W-1:0] - IDX_W'(1);
                  state_in    = ST_SCMP;
               end
            end
         end
         ST_SCMP: begin
            if (ord_rd_data.score < cur_ff.score) begin
               // shift the lower entry up one place
               ord_wr_en   = 1'b1;
               ord_wr_data = ord_rd_data;
               j_in        = j_ff - CNT_W'(1);
               if (j_ff == CNT_W'(1)) begin
                  state_in = ST_SINS;
               end else begin
                  ord_rd_en   = 1'b1;
                  ord_rd_addr = j_m2[IDX_W-1:0];
               end
            end else begin
               ord_wr_en = 1'b1;
               n_in      = n_ff + CNT_W'(1);
               i_in      = i_ff + CNT_W'(1);
               state_in  = ST_SRD;
            end
         end
         ST_SINS: begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = '0;
            n_in        = n_ff + CNT_W'(1);
            i_in        = i_ff + CNT_W'(1);
            state_in    = ST_SRD;
         end
         ST_PRD: begin
            if (i_ff == n_ff) begin
               flush_in = 1'b1;
               state_in = ST_LOAD;
            end else begin
               ord_rd_en = 1'b1;
               state_in  = ST_PCHK;
            end
         end
         ST_PCHK: begin
            if (ord_rd_data.supp) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_PRD;
            end else begin
               cur_in    = ord_rd_data;
               box_rd_en = 1'b1;
               state_in  = ST_PEMIT;
            end
         end
         ST_PEMIT: begin
            // hold the reference box, send the previous survivor
            box_a_in = box_rd_data;
            if (!pend_valid_ff || slot_free) begin
               push        = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_idx_in = cur_ff.idx;
               j_in        = i_ff + CNT_W'(1);
               state_in    = ST_QRD;
            end
         end
         ST_QRD: begin
            if (j_ff == n_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_PRD;
            end else begin
               ord_rd_en   = 1'b1;
               ord_rd_addr = j_ff[IDX_W-1:0];
               state_in    = ST_QCHK;
            end
         end
         ST_QCHK: begin
            cmp_in = ord_rd_data;
            if (ord_rd_data.supp) begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_QRD;
            end else begin
               box_rd_en = 1'b1;
               iou_start = 1'b0;
               state_in  = ST_QWAIT;
               flush_in  = flush_ff;
            end
         end
         ST_QWAIT: begin
            // launch on the first cycle, then wait for the verdict
            iou_start = !wait_ff;
            if (iou_res.done) begin
               if (iou_res.over) begin
                  ord_wr_en   = 1'b1;
                  ord_wr_data = '{score: cmp_ff.score, idx: cmp_ff.idx, supp: 1'b1};
               end
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_QRD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // mark that the IoU pipeline has been launched for this pair
   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff <= 1'b0;
      end else if (state_ff != ST_QWAIT) begin
         wait_ff <= 1'b0;
      end else begin
         wait_ff <= !iou_res.done;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         i_ff          <= '0;
         n_ff          <= '0;
         j_ff          <= '0;
         pend_valid_ff <= 1'b0;
         flush_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         score_thr_ff  <= SCORE_THR_RESET;
         iou_thr_ff    <= IOU_THR_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         i_ff          <= i_in;
         n_ff          <= n_in;
         j_ff          <= j_in;
         pend_valid_ff <= pend_valid_in;
         flush_ff      <= flush_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SCORE_THR: score_thr_ff <= csr_wr_data;
               CSR_IOU_THR:   iou_thr_ff   <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      cur_ff      <= cur_in;
      cmp_ff      <= cmp_in;
      box_a_ff    <= box_a_in;
      if (push) begin
         rsp_idx_ff  <= push_idx;
         rsp_kept_ff <= push_kept;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_box_index   = rsp_idx_ff;
   assign rsp_kept        = rsp_kept_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

### src/gbnms_checker.sv
`include "greedy_box_nms_top_macros.svh"

module gbnms_checker import gbnms_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [IDX_W-1:0] rsp_box_index,
   input logic             rsp_kept,
   input logic             rsp_last_result
);

   // a stalled result beat stays put
   `GBNMS_CHECK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp beat dropped while stalled")
   `GBNMS_CHECK_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_box_index), "rsp index changed while stalled")

   // the empty-set marker is always the final beat
   `GBNMS_CHECK_SAME(a_marker_last, clock, reset, rsp_valid && !rsp_kept, rsp_last_result, "empty marker without last flag")

   // no new boxes while a result before the final one is still on the output
   `GBNMS_CHECK_SAME(a_busy_stall, clock, reset, rsp_valid && !rsp_last_result, req_stall, "input open during result delivery")

endmodule

bind greedy_box_nms_top gbnms_checker u_gbnms_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_box_index   (rsp_box_index),
   .rsp_kept        (rsp_kept),
   .rsp_last_result (rsp_last_result)
);
